[src/indexed_list_engine_defines.svh]
// Assertion macros shared by the list engine RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge out of reset.
`define ILE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
    else $error("list engine check failed");

// Same-cycle implication.
`define ILE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication.
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");

`else

`define ILE_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ILE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ILE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/ile_pkg.sv]
// Shared types and constants for the indexed list engine.
// No dependencies; used by the interfaces, controller, datapath and top.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int DEPTH  = 64;  // list capacity
  localparam int ELEM_W = 32;  // stored element width
  localparam int IDX_W  = 6;   // element index width
  localparam int CNT_W  = 7;   // count width, holds DEPTH itself
  localparam int POS_W  = 6;   // position field width
  localparam int VAL_W  = 32;  // value field width

  typedef logic [1:0] func_t;
  localparam func_t FN_PUSH   = 2'd0;
  localparam func_t FN_POP    = 2'd1;
  localparam func_t FN_INSERT = 2'd2;
  localparam func_t FN_REMOVE = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch input fields and status
    logic rd;      // read element at pointer
    logic rd_mv;   // read is a shift move (else a capture)
    logic step;    // advance pointer
    logic wr_val;  // write the operand value
    logic commit;  // update count, load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  ok;
    logic  at_end;
    logic  out_free;
  } sts_t;

endpackage

[src/ile_in_if.sv]
// Operation channel: valid/ready plus the operation fields.
// Depends on ile_pkg.
`timescale 1ns / 1ps

interface ile_in_if import ile_pkg::*; ();
  logic             valid;
  logic             ready;
  func_t            func;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

[src/ile_out_if.sv]
// Result channel: valid/ready plus read value, status and count.
// Depends on ile_pkg.
`timescale 1ns / 1ps

interface ile_out_if import ile_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  status_t          status;
  logic [CNT_W-1:0] count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

[src/indexed_list_engine.sv]
// Indexed list engine: fixed-capacity ordered list with push, pop, insert, remove-at.
// One operation at a time. An error goes straight to the result; push writes at the count,
// pop reads the top element, and insert and remove shift the elements between the position
// and the top of the list. The next operation is taken in the cycle after the result is
// committed. The shift moves one element a cycle through the one-read, one-write memory.
// Reset (rst_n, synchronous, active low) empties the list; element storage is not cleared.
`timescale 1ns / 1ps

module indexed_list_engine import ile_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  ile_in_if.sink   in_ch,
  ile_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Controller: idle waits for a transfer, dispatches on the latched op and
  // status, runs the read/shift sequence, then commits the result.
  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: element memory with registered read, shift pointer, count,
  // and the output register that frees the sequencer while a result waits.
  ile_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_ch.func),
    .in_position    (in_ch.position),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_value (out_ch.read_value),
    .out_status     (out_ch.status),
    .out_count      (out_ch.count)
  );

endmodule

[src/ile_ctrl.sv]
// Sequencer for the list engine: steps reads, shifts and writes.
// Depends on ile_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps

module ile_ctrl import ile_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_RDCAP = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (!sts.ok) begin
          state_nxt = S_DONE;
        end else begin
          unique case (sts.func)
            FN_PUSH:   state_nxt = S_FINAL;
            FN_POP:    state_nxt = S_RDCAP;
            FN_INSERT: state_nxt = S_MOVE;
            FN_REMOVE: state_nxt = S_RDCAP;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_RDCAP: begin
        cmd.rd = 1'b1;
        if (sts.at_end) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.rd    = 1'b1;
        cmd.rd_mv = 1'b1;
        if (sts.at_end) state_nxt = S_DRAIN;
        else cmd.step = 1'b1;
      end
      S_DRAIN: begin
        state_nxt = (sts.func == FN_INSERT) ? S_FINAL : S_DONE;
      end
      S_FINAL: begin
        cmd.wr_val = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[src/ile_dp.sv]
// Datapath for the list engine: element memory, pointers, status, result register.
// Depends on ile_pkg and the assertion macros; commanded by ile_ctrl.
`timescale 1ns / 1ps
`include "indexed_list_engine_defines.svh"

module ile_dp import ile_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  func_t            in_func,
  input  logic [POS_W-1:0] in_position,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_read_value,
  output status_t          out_status,
  output logic [CNT_W-1:0] out_count
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [ELEM_W-1:0] mem_r [DEPTH];
  logic [ELEM_W-1:0] mem_q_r;

  func_t             func_r;
  logic [IDX_W-1:0]  pos_r;
  logic [ELEM_W-1:0] val_r;
  status_t           status_r;
  status_t           status_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [IDX_W-1:0]  ptr_r;
  logic [IDX_W-1:0]  end_r;
  logic [IDX_W-1:0]  ptr_init;
  logic [IDX_W-1:0]  end_init;
  logic [IDX_W-1:0]  mv_addr_r;
  logic              mv_pend_r;
  logic              cap_pend_r;
  logic [ELEM_W-1:0] rd_value_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [CNT_W-1:0]  pos_ext;
  logic [IDX_W-1:0]  last_idx;

  assign pos_ext  = CNT_W'(in_position);
  assign last_idx = IDX_W'(count_r - ONE_C);

  // status of the incoming operation against the current count
  always_comb begin
    status_nxt = ST_OK;
    unique case (in_func)
      FN_PUSH:   if (count_r >= DEPTH_C) status_nxt = ST_FULL;
      FN_POP:    if (count_r == '0) status_nxt = ST_EMPTY;
      FN_INSERT: begin
        if (pos_ext >= count_r) status_nxt = ST_RANGE;
        else if (count_r >= DEPTH_C) status_nxt = ST_FULL;
      end
      FN_REMOVE: begin
        if (count_r == '0) status_nxt = ST_EMPTY;
        else if (pos_ext >= count_r) status_nxt = ST_RANGE;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // insert walks down from the top element, remove walks up from the index
  always_comb begin
    ptr_init = last_idx;
    end_init = last_idx;
    unique case (in_func)
      FN_INSERT: end_init = IDX_W'(in_position);
      FN_REMOVE: ptr_init = IDX_W'(in_position);
      default: begin
        ptr_init = last_idx;
        end_init = last_idx;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (status_r == ST_OK) begin
      if (func_r == FN_PUSH || func_r == FN_INSERT) count_nxt = count_r + ONE_C;
      else count_nxt = count_r - ONE_C;
    end
  end

  // single write port: a pending shift move or the operand value
  assign wr_en   = mv_pend_r | cmd.wr_val;
  assign wr_data = mv_pend_r ? mem_q_r : val_r;
  always_comb begin
    if (mv_pend_r) begin
      wr_addr = (func_r == FN_INSERT) ? mv_addr_r + IDX_W'(1) : mv_addr_r - IDX_W'(1);
    end else begin
      wr_addr = (func_r == FN_PUSH) ? IDX_W'(count_r) : pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (cmd.rd) mem_q_r <= mem_r[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_func;
      pos_r    <= IDX_W'(in_position);
      val_r    <= ELEM_W'(in_value);
      status_r <= status_nxt;
      ptr_r    <= ptr_init;
      end_r    <= end_init;
    end else if (cmd.step) begin
      ptr_r <= (func_r == FN_INSERT) ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
    end
    if (cmd.rd) mv_addr_r <= ptr_r;
    if (cmd.accept) rd_value_r <= '0;
    else if (cap_pend_r) rd_value_r <= mem_q_r;
    if (cmd.commit) begin
      out_value_r  <= VAL_W'(rd_value_r);
      out_status_r <= status_r;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mv_pend_r   <= 1'b0;
      cap_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mv_pend_r  <= cmd.rd & cmd.rd_mv;
      cap_pend_r <= cmd.rd & ~cmd.rd_mv;
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.func     = func_r;
  assign sts.ok       = (status_r == ST_OK);
  assign sts.at_end   = (ptr_r == end_r);
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  `ILE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= DEPTH_C)
  `ILE_ASSERT_ALWAYS(a_one_writer, clk, rst_n, !(mv_pend_r && cmd.wr_val))
  `ILE_ASSERT_NEXT(a_fail_keeps, clk, rst_n, cmd.commit && status_r != ST_OK, count_r == $past(count_r))

endmodule

[tb/tb_indexed_list_engine.sv]
// Self-checking testbench for indexed_list_engine: directed corner cases, then random
// grow/shrink/mixed phases with random idling on both channels and one long output stall.
// Depends on ile_pkg, ile_in_if, ile_out_if and the engine RTL.
`timescale 1ns / 1ps

module tb_indexed_list_engine;
  import ile_pkg::*;

  localparam int RAND_ITEMS  = 450;
  localparam int HOLD_CYCLES = 300;   // long output stall, fills the engine
  localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles without any transfer
  localparam int TAIL_CYCLES = 80;    // wait after the last result, covers the longest shift

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    status_t          status;
    logic [CNT_W-1:0] count;
  } list_result_t;

  // Mirror of the list contents; computes the result of every accepted operation.
  class list_mirror;
    logic [ELEM_W-1:0] elems [DEPTH];
    int unsigned       count;
    list_result_t      expected_results [$];
    int                errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void apply_op(func_t fn, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      list_result_t r;
      int           i;
      r.read_value = '0;
      r.status     = ST_OK;
      case (fn)
        FN_PUSH: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            elems[count] = val;
            count++;
          end
        end
        FN_POP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            count--;
            r.read_value = elems[count];
          end
        end
        FN_INSERT: begin
          // index is checked before fullness
          if (pos >= count) begin
            r.status = ST_RANGE;
          end else if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > pos; i--) elems[i] = elems[i-1];
            elems[pos] = val;
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= count) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = elems[pos];
            for (i = pos; i + 1 < count; i++) elems[i] = elems[i+1];
            count--;
          end
        end
      endcase
      r.count = count[CNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [VAL_W-1:0] rv, status_t st, logic [CNT_W-1:0] cnt);
      list_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: read_value %h status %0d count %0d",
               rv, st, cnt);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (rv !== exp_r.read_value) begin
        $error("read_value mismatch: expected %h, actual %h", exp_r.read_value, rv);
        errors++;
      end
      if (st !== exp_r.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_r.status, st);
        errors++;
      end
      if (cnt !== exp_r.count) begin
        $error("count mismatch: expected %0d, actual %0d", exp_r.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ile_in_if  in_ch ();
  ile_out_if out_ch ();

  indexed_list_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_mirror mirror;
  bit         tx_burst;   // sender: no gaps while set
  bit         rx_burst;   // receiver: no stalls while set
  bit         hold_req;   // ask the receiver for one long stall
  int         idle_cycles;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one operation and wait for its transfer. Entered and left at a falling edge;
  // valid stays high on return so back-to-back items need no toggle.
  task automatic send_op(input func_t fn, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func     = fn;
    in_ch.position = pos;
    in_ch.value    = val;
    in_ch.valid    = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    mirror.apply_op(fn, pos, val);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    @(negedge clk);
  endtask

  // add_pct: chance of push/insert versus pop/remove.
  task automatic send_random(input int add_pct);
    func_t            fn;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               sel;
    if ($urandom_range(0, 99) < add_pct) begin
      fn = $urandom_range(0, 1) ? FN_PUSH : FN_INSERT;
    end else begin
      fn = $urandom_range(0, 1) ? FN_POP : FN_REMOVE;
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      pos = mirror.count[POS_W-1:0];  // just past the end (wraps when full)
    end else if (sel == 1 || mirror.count == 0) begin
      pos = POS_W'($urandom_range(0, 63));
    end else begin
      pos = POS_W'($urandom_range(0, mirror.count - 1));
    end
    sel = $urandom_range(0, 7);
    if (sel == 0) val = '0;
    else if (sel == 1) val = '1;
    else val = $urandom;
    send_op(fn, pos, val);
  endtask

  // Result sink with random stalls and the one long hold-off.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          out_ch.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      mirror.check_result(out_ch.read_value, out_ch.status, out_ch.count);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      @(negedge clk);
    end
  end

  initial begin : op_source
    int sent;
    int n;
    int extra;
    int phase;
    mirror         = new();
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    hold_req       = 1'b0;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_PUSH;
    in_ch.position = '0;
    in_ch.value    = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-list errors, value extremes, index boundaries
    send_op(FN_POP, 6'd0, 32'h0);
    send_op(FN_REMOVE, 6'd0, 32'h0);
    send_op(FN_INSERT, 6'd0, 32'h1111_1111);
    send_op(FN_PUSH, 6'd63, 32'h0000_0000);
    send_op(FN_PUSH, 6'd0, 32'hFFFF_FFFF);
    send_op(FN_PUSH, 6'd0, 32'hA5A5_5A5A);
    send_op(FN_INSERT, 6'd0, 32'h0000_0001);
    send_op(FN_INSERT, mirror.count[POS_W-1:0] - 1'b1, 32'h8000_0000);  // last index
    send_op(FN_INSERT, mirror.count[POS_W-1:0], 32'h1234_5678);         // at count
    send_op(FN_INSERT, 6'd63, 32'h5555_AAAA);
    send_op(FN_REMOVE, 6'd63, 32'h0);
    send_op(FN_REMOVE, mirror.count[POS_W-1:0], 32'h0);
    send_op(FN_REMOVE, mirror.count[POS_W-1:0] - 1'b1, 32'h0);          // last index
    send_op(FN_REMOVE, 6'd0, 32'h0);
    send_op(FN_REMOVE, 6'd1, 32'h0);
    send_op(FN_POP, 6'd0, 32'h0);
    send_op(FN_PUSH, 6'd0, 32'h7FFF_FFFF);
    send_op(FN_PUSH, 6'd0, 32'hDEAD_BEEF);
    send_op(FN_INSERT, 6'd1, 32'hC0FF_EE00);
    send_op(FN_POP, 6'd0, 32'h0);
    send_op(FN_POP, 6'd0, 32'h0);
    send_op(FN_POP, 6'd0, 32'h0);
    send_op(FN_POP, 6'd0, 32'h0);

    // random: grow to full and linger, drain to empty and linger, then mixed
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      n     = 0;
      extra = 0;
      if (phase == 1) hold_req = 1'b1;
      case (phase % 3)
        0: begin
          while (n < 160 && extra < 20) begin
            send_random(80);
            n++;
            if (mirror.count == DEPTH) extra++;
          end
        end
        1: begin
          while (n < 160 && extra < 15) begin
            send_random(20);
            n++;
            if (mirror.count == 0) extra++;
          end
        end
        default: begin
          while (n < 100) begin
            send_random(50);
            n++;
          end
        end
      endcase
      sent += n;
      phase++;
    end
    in_ch.valid = 1'b0;

    while (mirror.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
